>>> rtl/slcb_pkg.sv
package slcb_pkg;

  localparam int DATA_W         = 64;
  localparam int OPCODE_W       = 3;
  localparam int AGENT_W        = 4;
  localparam int DIVISOR_W      = 5;
  localparam int CFG_ADDR_W     = 5;
  localparam int MAX_AGENTS_DEF = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_ADD        = 3'd2,
    OP_SUB        = 3'd3,
    OP_READ       = 3'd4
  } slcb_op_t;

  typedef enum logic [1:0] {
    REG_COUNT_LIMIT   = 2'd0,
    REG_AGENT_CAP     = 2'd1,
    REG_ONLINE_AGENTS = 2'd2
  } slcb_reg_t;

  // configuration as seen by the sequencer
  typedef struct packed {
    logic [DATA_W-1:0]    count_limit;
    logic [DATA_W-1:0]    agent_cap;
    logic [DIVISOR_W-1:0] divisor;
  } slcb_cfg_t;

  // one agent entry: local count and local reserve
  typedef struct packed {
    logic [DATA_W-1:0] lcount;
    logic [DATA_W-1:0] lreserve;
  } slcb_entry_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic done;
  } slcb_div_ctl_t;

endpackage

>>> rtl/slcb_in_if.sv
interface slcb_in_if;
  import slcb_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [AGENT_W-1:0]  agent;
  logic [DATA_W-1:0]   amount;

  modport source (output valid, output opcode, output agent, output amount, input ready);
  modport sink   (input valid, input opcode, input agent, input amount, output ready);
endinterface

>>> rtl/slcb_out_if.sv
interface slcb_out_if;
  import slcb_pkg::*;

  logic              valid;
  logic              ready;
  logic              success;
  logic [DATA_W-1:0] total;

  modport source (output valid, output success, output total, input ready);
  modport sink   (input valid, input success, input total, output ready);
endinterface

>>> rtl/slcb_cfg.sv
module slcb_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [slcb_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [slcb_pkg::DATA_W-1:0]   pwdata,
  output logic [slcb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output slcb_pkg::slcb_cfg_t           cfg
);
  import slcb_pkg::*;

  logic [DATA_W-1:0]    count_limit_r;
  logic [DATA_W-1:0]    agent_cap_r;
  logic [DIVISOR_W-1:0] online_agents_r;
  slcb_reg_t            reg_sel;
  logic                 wr_en;

  assign reg_sel = slcb_reg_t'(paddr[CFG_ADDR_W-1:3]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_limit_r   <= '0;
      agent_cap_r     <= '0;
      online_agents_r <= DIVISOR_W'(1);
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_COUNT_LIMIT:   count_limit_r   <= pwdata;
        REG_AGENT_CAP:     agent_cap_r     <= pwdata;
        REG_ONLINE_AGENTS: online_agents_r <= pwdata[DIVISOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_COUNT_LIMIT:   prdata = count_limit_r;
      REG_AGENT_CAP:     prdata = agent_cap_r;
      REG_ONLINE_AGENTS: prdata = {{(DATA_W-DIVISOR_W){1'b0}}, online_agents_r};
      default:           prdata = '0;
    endcase
  end

  // zero agents divides as one
  assign cfg.count_limit = count_limit_r;
  assign cfg.agent_cap   = agent_cap_r;
  assign cfg.divisor     = (online_agents_r == '0) ? DIVISOR_W'(1) : online_agents_r;
endmodule

>>> rtl/slcb_div.sv
module slcb_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [slcb_pkg::DATA_W-1:0]    dividend,
  input  logic [slcb_pkg::DIVISOR_W-1:0] divisor,
  output logic                           done,
  output logic [slcb_pkg::DATA_W-1:0]    quotient
);
  import slcb_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic                 busy_r;
  logic                 done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DIVISOR_W-1:0] rem_r;
  logic [DIVISOR_W-1:0] dsr_r;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 q_bit;

  // restoring division, one quotient bit a cycle
  assign rem_sh  = {rem_r, quo_r[DATA_W-1]};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign q_bit   = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DATA_W);
        quo_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DATA_W-2:0], q_bit};
        rem_r <= q_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;
endmodule

>>> rtl/slcb_mem.sv
module slcb_mem #(
  parameter int DEPTH = slcb_pkg::MAX_AGENTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output slcb_pkg::slcb_entry_t rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  slcb_pkg::slcb_entry_t wr_data
);
  import slcb_pkg::*;

  slcb_entry_t      mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  slcb_entry_t      rd_q_r;
  logic             rd_vld_r;

  // storage and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;
endmodule

>>> rtl/shared_limit_counter_budget.sv
// Shared limit counter with per-agent budgets. A global count bounded by
// count_limit is shared among agents; each agent entry (local count and
// local reserve) sits in a small synchronous memory, the global count and
// global reserve in registers. One request is worked at a time: the input
// channel is ready only while the sequencer is idle, and a finished result
// waits in the output register so the next request can be taken meanwhile.
// Per request, register and invalid requests go straight from accept to the
// result; unregister folds and writes back the entry; add or subtract folds,
// tests the headroom and, on success, runs the reserve division in an
// iterative divider at one quotient bit per cycle; read walks every entry
// through the single memory read port. Entries are valid-tagged, so no
// clearing pass follows reset. Configuration goes through the APB-style port,
// registers at byte addresses 0 (count_limit, 64-bit), 8 (agent_cap, 64-bit)
// and 16 (online_agents, 5-bit); write it only while no request is in flight.
module shared_limit_counter_budget #(
  parameter int MAX_AGENTS = slcb_pkg::MAX_AGENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  slcb_in_if.sink                         in_req,
  slcb_out_if.source                      out_rsp,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [slcb_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [slcb_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [slcb_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import slcb_pkg::*;

  localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
  localparam int XW = (AW > AGENT_W) ? AW : AGENT_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_AGENTS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_FOLD,
    S_HEAD,
    S_TEST,
    S_NUM,
    S_NUM2,
    S_DIV_GO,
    S_DIV_WAIT,
    S_RES,
    S_LOC,
    S_WRITE,
    S_WALK_RD,
    S_WALK_ACC,
    S_DONE
  } state_t;

  // configuration registers
  slcb_cfg_t cfg;

  slcb_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  state_t                state_r;
  slcb_op_t              op_r;
  logic [AW-1:0]         agent_r;
  logic [DATA_W-1:0]     amt_r;
  logic [DATA_W-1:0]     gc_r;        // global count
  logic [DATA_W-1:0]     gr_r;        // global reserved
  logic [DATA_W-1:0]     head_r;      // headroom scratch
  logic [DATA_W-1:0]     res_r;       // new local reserve
  logic [DATA_W-1:0]     loc_r;       // new local count
  logic [DATA_W-1:0]     tot_r;
  logic                  ok_r;
  logic [AW-1:0]         idx_r;       // read walk index
  logic [MAX_AGENTS-1:0] present_r;
  logic                  out_vld_r;
  logic                  out_ok_r;
  logic [DATA_W-1:0]     out_tot_r;

  logic                  in_acc;
  logic [XW-1:0]         in_agent_x;
  logic [AW-1:0]         in_addr;
  logic                  in_agent_ok;
  slcb_op_t              in_op;
  logic                  out_free;
  logic                  out_load;
  logic [DATA_W-1:0]     head_left;
  logic                  pass;

  // memory port signals
  logic                  mem_rd_en;
  logic [AW-1:0]         mem_rd_addr;
  slcb_entry_t           mem_rd_data;
  logic                  mem_wr_en;
  slcb_entry_t           mem_wr_data;

  // divider
  slcb_div_ctl_t         div_ctl;
  logic [DATA_W-1:0]     div_q;

  assign in_req.ready = (state_r == S_IDLE);
  assign in_acc       = in_req.valid && in_req.ready;
  assign in_op        = slcb_op_t'(in_req.opcode);
  assign in_agent_x   = XW'(in_req.agent);
  assign in_addr      = in_agent_x[AW-1:0];
  assign in_agent_ok  = (int'(in_req.agent) < MAX_AGENTS);
  assign out_free     = !out_vld_r || out_rsp.ready;
  // finished result moves into the output register
  assign out_load     = (state_r == S_DONE) && out_free;

  // the entry is fetched as the request is taken, ready on the next cycle
  assign mem_rd_en   = in_acc || (state_r == S_WALK_RD);
  assign mem_rd_addr = (state_r == S_WALK_RD) ? idx_r : in_addr;
  assign mem_wr_en   = (state_r == S_WRITE);
  assign mem_wr_data = '{lcount: loc_r, lreserve: res_r};

  slcb_mem #(
    .DEPTH (MAX_AGENTS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (agent_r),
    .wr_data (mem_wr_data)
  );

  assign div_ctl.start = (state_r == S_DIV_GO);

  slcb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_ctl.start),
    .dividend (head_r),
    .divisor  (cfg.divisor),
    .done     (div_ctl.done),
    .quotient (div_q)
  );

  // headroom after the fold, and the add or subtract test
  assign head_left = head_r - gr_r;
  always_comb begin
    case (op_r)
      OP_ADD:  pass = (head_left >= amt_r);
      default: pass = (gc_r >= amt_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      gc_r      <= '0;
      gr_r      <= '0;
      present_r <= '0;
      out_vld_r <= 1'b0;
      ok_r      <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_vld_r && out_rsp.ready) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            op_r    <= in_op;
            agent_r <= in_addr;
            amt_r   <= in_req.amount;
            ok_r    <= 1'b0;
            tot_r   <= (in_op == OP_READ) ? gc_r : '0;
            loc_r   <= '0;
            res_r   <= '0;
            if (in_op == OP_READ) begin
              idx_r   <= '0;
              state_r <= S_WALK_RD;
            end else if (!in_agent_ok) begin
              state_r <= S_DONE;
            end else begin
              case (in_op) inside
                OP_REGISTER: begin
                  present_r[in_addr] <= 1'b1;
                  state_r            <= S_DONE;
                end
                OP_UNREGISTER, OP_ADD, OP_SUB: state_r <= S_FOLD;
                default:                       state_r <= S_DONE;
              endcase
            end
          end
        end

        // fold the agent entry back into the global totals
        S_FOLD: begin
          gc_r <= gc_r + mem_rd_data.lcount;
          gr_r <= gr_r - mem_rd_data.lreserve;
          if (op_r == OP_UNREGISTER) begin
            present_r[agent_r] <= 1'b0;
            state_r            <= S_WRITE;
          end else begin
            state_r <= S_HEAD;
          end
        end

        S_HEAD: begin
          head_r  <= cfg.count_limit - gc_r;
          state_r <= S_TEST;
        end

        S_TEST: begin
          if (pass) begin
            gc_r    <= (op_r == OP_ADD) ? gc_r + amt_r : gc_r - amt_r;
            ok_r    <= 1'b1;
            state_r <= S_NUM;
          end else begin
            state_r <= S_WRITE;
          end
        end

        // headroom left after the request, to be shared out
        S_NUM: begin
          head_r  <= cfg.count_limit - gc_r;
          state_r <= S_NUM2;
        end

        S_NUM2: begin
          head_r  <= head_left;
          state_r <= S_DIV_GO;
        end

        S_DIV_GO: begin
          state_r <= S_DIV_WAIT;
        end

        S_DIV_WAIT: begin
          if (div_ctl.done) begin
            res_r   <= (div_q > cfg.agent_cap) ? cfg.agent_cap : div_q;
            state_r <= S_RES;
          end
        end

        // book the reserve, take half of it (at most the global count) out of the global count
        S_RES: begin
          gr_r    <= gr_r + res_r;
          loc_r   <= ((res_r >> 1) > gc_r) ? gc_r : (res_r >> 1);
          state_r <= S_LOC;
        end

        S_LOC: begin
          gc_r    <= gc_r - loc_r;
          state_r <= S_WRITE;
        end

        S_WRITE: begin
          state_r <= S_DONE;
        end

        // read: each entry is fetched in S_WALK_RD and, if present, summed in S_WALK_ACC
        S_WALK_RD: begin
          state_r <= S_WALK_ACC;
        end

        S_WALK_ACC: begin
          if (present_r[idx_r]) begin
            tot_r <= tot_r + mem_rd_data.lcount;
          end
          if (idx_r == LAST_IDX) begin
            state_r <= S_DONE;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_WALK_RD;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_ok_r  <= ok_r;
            out_tot_r <= tot_r;
            state_r   <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_rsp.valid   = out_vld_r;
  assign out_rsp.success = out_ok_r;
  assign out_rsp.total   = out_tot_r;

  // memory is never written and read in the same cycle
  a_mem_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_wr_en && mem_rd_en))
    else $error("memory read and write overlap");

  // divider never reports done straight after a start
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |=> !div_ctl.done)
    else $error("divider done right after start");

  // only an add or subtract can succeed
  a_ok_only_arith: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && ok_r) |-> (op_r == OP_ADD || op_r == OP_SUB))
    else $error("success flagged for a non-arithmetic request");

  // a total is reported for reads only
  a_total_read_only: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && op_r != OP_READ) |-> (tot_r == '0))
    else $error("nonzero total for a non-read request");

  // a result is loaded only when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_vld_r && !out_rsp.ready) |=> (state_r == S_DONE))
    else $error("result dropped while output stalled");
endmodule
